@@ src/ecnq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ECN queue package
// Shared constants, register codes and stage records of the byte queue
// with RED-style ECN marking.
// ----------------------------------------------------------------------------
package ecnq_pkg;

   localparam int QUEUE_DEPTH = 1024;
   localparam int SIZE_BITS   = 14;
   localparam int BYTE_BITS   = 24;
   localparam int RND_BITS    = 16;
   localparam int PROB_BITS   = 17;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   localparam int PROD_SPAN_BITS   = RND_BITS + BYTE_BITS;
   localparam int PROD_EXCESS_BITS = PROB_BITS + BYTE_BITS;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam int REQ_FIELD_BITS = SIZE_BITS + RND_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 3 + SIZE_BITS + BYTE_BITS + COUNT_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic [BYTE_BITS-1:0] MARK_LOW_RESET   = BYTE_BITS'(16777214);
   localparam logic [BYTE_BITS-1:0] MARK_HIGH_RESET  = BYTE_BITS'(16777215);
   localparam logic [PROB_BITS-1:0] MAX_PROB_RESET   = '0;
   localparam logic [BYTE_BITS-1:0] BYTE_LIMIT_RESET = BYTE_BITS'(16777215);

   typedef enum logic [1:0] {
      REG_MARK_LOW   = 2'd0,
      REG_MARK_HIGH  = 2'd1,
      REG_MAX_PROB   = 2'd2,
      REG_BYTE_LIMIT = 2'd3
   } csr_reg_type;

   typedef enum logic {
      MODE_ENQUEUE = 1'b0,
      MODE_DEQUEUE = 1'b1
   } mode_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] mark_low;
      logic [BYTE_BITS-1:0] mark_high;
      logic [PROB_BITS-1:0] max_prob;
      logic [BYTE_BITS-1:0] byte_limit;
   } cfg_type;

   // queue update done, mark decision operands captured
   typedef struct packed {
      logic                  accepted;
      logic                  pkt_valid;
      logic [SIZE_BITS-1:0]  out_size;
      logic [BYTE_BITS-1:0]  queue_bytes;
      logic [COUNT_BITS-1:0] queue_packets;
      logic                  at_low;
      logic                  at_high;
      logic [RND_BITS-1:0]   rnd;
      logic [BYTE_BITS-1:0]  span;
      logic [BYTE_BITS-1:0]  excess;
   } stage1_type;

   // products formed, compare still to do
   typedef struct packed {
      logic                        accepted;
      logic                        pkt_valid;
      logic [SIZE_BITS-1:0]        out_size;
      logic [BYTE_BITS-1:0]        queue_bytes;
      logic [COUNT_BITS-1:0]       queue_packets;
      logic                        at_low;
      logic                        at_high;
      logic [PROD_SPAN_BITS-1:0]   prod_span;
      logic [PROD_EXCESS_BITS-1:0] prod_excess;
   } stage2_type;

   typedef struct packed {
      logic                  accepted;
      logic                  out_valid;
      logic [SIZE_BITS-1:0]  out_size;
      logic                  ecn_mark;
      logic [BYTE_BITS-1:0]  queue_bytes;
      logic [COUNT_BITS-1:0] queue_packets;
   } result_type;

   function automatic logic [PTR_BITS-1:0] ptr_incr(input logic [PTR_BITS-1:0] ptr);
      logic [PTR_BITS-1:0] nxt;
      if (ptr == PTR_BITS'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + PTR_BITS'(1);
      end
      return nxt;
   endfunction

endpackage
`default_nettype wire

@@ src/ecnq_size_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ECN queue size store
// One write and one registered read port; a write to the address being read
// is forwarded so the read returns the new size.
// ----------------------------------------------------------------------------
module ecnq_size_ram
   import ecnq_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_en,
   input  wire logic [PTR_BITS-1:0]  wr_addr,
   input  wire logic [SIZE_BITS-1:0] wr_data,
   input  wire logic [PTR_BITS-1:0]  rd_addr,
   output logic      [SIZE_BITS-1:0] rd_data
);

   logic [SIZE_BITS-1:0] size_mem [QUEUE_DEPTH];
   logic [SIZE_BITS-1:0] rd_q_ff;
   logic [SIZE_BITS-1:0] byp_data_ff;
   logic                 byp_hit_ff;
   logic                 byp_hit_in;

   assign byp_hit_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         size_mem[wr_addr] <= wr_data;
      end
      rd_q_ff     <= size_mem[rd_addr];
      byp_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_hit_ff <= 1'b0;
      end else begin
         byp_hit_ff <= byp_hit_in;
      end
   end

   assign rd_data = byp_hit_ff ? byp_data_ff : rd_q_ff;

endmodule
`default_nettype wire

@@ src/ecnq_queue_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ECN queue control
// Admission, pointers and occupancy; loads the first stage record.
// ----------------------------------------------------------------------------
module ecnq_queue_ctrl
   import ecnq_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cfg_type              cfg,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic                 mode,
   input  wire logic [SIZE_BITS-1:0] packet_size,
   input  wire logic [RND_BITS-1:0]  random_value,
   input  wire logic [SIZE_BITS-1:0] head_size,
   output logic                      wr_en,
   output logic      [PTR_BITS-1:0]  wr_addr,
   output logic      [SIZE_BITS-1:0] wr_data,
   output logic      [PTR_BITS-1:0]  rd_addr,
   input  wire logic                 s1_take,
   output logic                      s1_valid,
   output stage1_type                s1
);

   logic [PTR_BITS-1:0]   head_ff,  head_in;
   logic [PTR_BITS-1:0]   tail_ff,  tail_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [BYTE_BITS-1:0]  bytes_ff, bytes_in;
   logic                  s1_valid_ff, s1_valid_in;
   stage1_type            s1_ff, s1_in;

   logic                  accept;
   logic                  is_deq;
   logic                  enq_ok;
   logic                  deq_ok;
   logic [BYTE_BITS:0]    sum;
   logic [BYTE_BITS-1:0]  head_ext;
   logic [BYTE_BITS-1:0]  deq_bytes;

   assign in_ready = !s1_valid_ff || s1_take;
   assign accept   = in_valid && in_ready;
   assign is_deq   = (mode_type'(mode) == MODE_DEQUEUE);

   assign sum      = {1'b0, bytes_ff} + (BYTE_BITS+1)'(packet_size);
   assign enq_ok   = !is_deq && (count_ff < COUNT_BITS'(QUEUE_DEPTH))
                     && (sum <= {1'b0, cfg.byte_limit});
   assign deq_ok   = is_deq && (count_ff != '0);
   assign head_ext = BYTE_BITS'(head_size);
   assign deq_bytes = (bytes_ff >= head_ext) ? (bytes_ff - head_ext) : '0;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      bytes_in = bytes_ff;
      if (accept && enq_ok) begin
         tail_in  = ptr_incr(tail_ff);
         count_in = count_ff + COUNT_BITS'(1);
         bytes_in = sum[BYTE_BITS-1:0];
      end else if (accept && deq_ok) begin
         head_in  = ptr_incr(head_ff);
         count_in = count_ff - COUNT_BITS'(1);
         bytes_in = deq_bytes;
      end
   end

   always_comb begin
      s1_in.accepted      = enq_ok;
      s1_in.pkt_valid     = deq_ok;
      s1_in.out_size      = deq_ok ? head_size : '0;
      s1_in.queue_bytes   = bytes_in;
      s1_in.queue_packets = count_in;
      s1_in.at_low        = (bytes_ff <= cfg.mark_low);
      s1_in.at_high       = (bytes_ff >= cfg.mark_high);
      s1_in.rnd           = random_value;
      s1_in.span          = cfg.mark_high - cfg.mark_low;
      s1_in.excess        = bytes_ff - cfg.mark_low;
   end

   assign s1_valid_in = accept ? 1'b1 : (s1_take ? 1'b0 : s1_valid_ff);

   // read the head the queue will have after this beat
   assign rd_addr = head_in;
   assign wr_en   = accept && enq_ok;
   assign wr_addr = tail_ff;
   assign wr_data = packet_size;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         bytes_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         bytes_ff    <= bytes_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1       = s1_ff;

endmodule
`default_nettype wire

@@ src/ecnq_marker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ECN queue marker
// Multiply stage, compare stage and result register of the mark decision.
// ----------------------------------------------------------------------------
module ecnq_marker
   import ecnq_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [PROB_BITS-1:0] max_prob,
   input  wire logic                 s1_valid,
   input  wire stage1_type           s1,
   output logic                      s1_take,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output result_type                out
);

   logic       s2_valid_ff, s2_valid_in;
   stage2_type s2_ff, s2_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       s2_take;
   logic       prob_hit;

   assign s2_take = !out_valid_ff || out_ready;
   assign s1_take = !s2_valid_ff || s2_take;

   // max_prob must only change with nothing in flight; the block does not enforce this and reads it live here
   always_comb begin
      s2_in.accepted      = s1.accepted;
      s2_in.pkt_valid     = s1.pkt_valid;
      s2_in.out_size      = s1.out_size;
      s2_in.queue_bytes   = s1.queue_bytes;
      s2_in.queue_packets = s1.queue_packets;
      s2_in.at_low        = s1.at_low;
      s2_in.at_high       = s1.at_high;
      s2_in.prod_span     = PROD_SPAN_BITS'(s1.rnd) * PROD_SPAN_BITS'(s1.span);
      s2_in.prod_excess   = PROD_EXCESS_BITS'(s1.excess) * PROD_EXCESS_BITS'(max_prob);
   end

   assign prob_hit = PROD_EXCESS_BITS'(s2_ff.prod_span) < s2_ff.prod_excess;

   always_comb begin
      out_in.accepted      = s2_ff.accepted;
      out_in.out_valid     = s2_ff.pkt_valid;
      out_in.out_size      = s2_ff.out_size;
      out_in.ecn_mark      = s2_ff.pkt_valid && !s2_ff.at_low && (s2_ff.at_high || prob_hit);
      out_in.queue_bytes   = s2_ff.queue_bytes;
      out_in.queue_packets = s2_ff.queue_packets;
   end

   assign s2_valid_in  = s1_take ? s1_valid : s2_valid_ff;
   assign out_valid_in = s2_take ? s2_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take && s1_valid) begin
         s2_ff <= s2_in;
      end
      if (s2_take && s2_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out       = out_ff;

endmodule
`default_nettype wire

@@ src/ecnq_csr.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ECN queue registers
// Configuration registers behind the register bus port.
// ----------------------------------------------------------------------------
module ecnq_csr
   import ecnq_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output cfg_type                       cfg
);

   cfg_type     cfg_ff, cfg_in;
   csr_reg_type reg_sel;
   logic        wr_stb;

   assign reg_sel = csr_reg_type'(paddr[CSR_ADDR_BITS-1:2]);
   assign wr_stb  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_stb) begin
         unique case (reg_sel)
            REG_MARK_LOW:   cfg_in.mark_low   = pwdata[BYTE_BITS-1:0];
            REG_MARK_HIGH:  cfg_in.mark_high  = pwdata[BYTE_BITS-1:0];
            REG_MAX_PROB:   cfg_in.max_prob   = pwdata[PROB_BITS-1:0];
            REG_BYTE_LIMIT: cfg_in.byte_limit = pwdata[BYTE_BITS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_MARK_LOW:   prdata = CSR_DATA_BITS'(cfg_ff.mark_low);
         REG_MARK_HIGH:  prdata = CSR_DATA_BITS'(cfg_ff.mark_high);
         REG_MAX_PROB:   prdata = CSR_DATA_BITS'(cfg_ff.max_prob);
         REG_BYTE_LIMIT: prdata = CSR_DATA_BITS'(cfg_ff.byte_limit);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mark_low   <= MARK_LOW_RESET;
         cfg_ff.mark_high  <= MARK_HIGH_RESET;
         cfg_ff.max_prob   <= MAX_PROB_RESET;
         cfg_ff.byte_limit <= BYTE_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

@@ src/fifo_byte_queue_ecn_marker.sv @@
`default_nettype none
// A request beat passes the stage-one record, the product record and the result register
// before its result beat is offered. One beat per cycle while the result stream is not stalled;
//   the queue state updates in the accept cycle and the size store reads the next head ahead of use.
// The mark decision runs over a multiply stage and a compare stage.
// Reset (synchronous, active high) empties the queue and loads register defaults.
// ----------------------------------------------------------------------------
// Byte queue with ECN marking
// Drop-tail packet FIFO tracking bytes and packets; marks dequeued packets
// with a RED-style probability taken from the occupancy before removal.
// ----------------------------------------------------------------------------
module fifo_byte_queue_ecn_marker
   import ecnq_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request stream
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // [13:0] packet_size, [29:14] random_value, rest zero
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   // [0] mode
   input  wire logic                     req_tuser,
   // result stream
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // [0] accepted, [1] out_valid, [15:2] out_size, [16] ecn_mark,
   // [40:17] queue_bytes, [51:41] queue_packets, rest zero
   output logic      [RSP_DATA_BITS-1:0] rsp_tdata,
   // configuration port
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready
);

   cfg_type              cfg;
   stage1_type           s1;
   result_type           res;
   logic                 s1_valid;
   logic                 s1_take;
   logic                 wr_en;
   logic [PTR_BITS-1:0]  wr_addr;
   logic [SIZE_BITS-1:0] wr_data;
   logic [PTR_BITS-1:0]  rd_addr;
   logic [SIZE_BITS-1:0] head_size;

   // no wait states on the register port
   assign csr_pready = 1'b1;

   ecnq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   // the size store always presents the current head's size
   ecnq_size_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (head_size)
   );

   // admit or drop, pop, advance pointers and occupancy
   ecnq_queue_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .mode         (req_tuser),
      .packet_size  (req_tdata[SIZE_BITS-1:0]),
      .random_value (req_tdata[SIZE_BITS +: RND_BITS]),
      .head_size    (head_size),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_addr      (rd_addr),
      .s1_take      (s1_take),
      .s1_valid     (s1_valid),
      .s1           (s1)
   );

   // cross-multiplied probability compare, then the result register
   ecnq_marker u_marker (
      .clock     (clock),
      .reset     (reset),
      .max_prob  (cfg.max_prob),
      .s1_valid  (s1_valid),
      .s1        (s1),
      .s1_take   (s1_take),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out       (res)
   );

   // pack result fields, lowest field first
   assign rsp_tdata = RSP_DATA_BITS'({res.queue_packets, res.queue_bytes, res.ecn_mark,
                                      res.out_size, res.out_valid, res.accepted});

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (res.queue_packets <= COUNT_BITS'(QUEUE_DEPTH)))
      else $error("packet count above queue depth");

   a_mark_needs_packet: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && res.ecn_mark) |-> (res.out_valid && !res.accepted))
      else $error("mark without a dequeued packet");

   a_empty_size: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !res.out_valid) |-> (res.out_size == '0))
      else $error("size reported with no packet");

   a_store_write_bound: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (u_ctrl.count_ff != '0))
      else $error("store write left the queue empty");
`endif

endmodule
`default_nettype wire
